>>> sv/point_segment_distance_assert.svh
// assertion macros for the point to segment distance block
`ifndef POINT_SEGMENT_DISTANCE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_ASSERT_SVH

// same-cycle implication, off during reset
`define PSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("point_segment_distance assertion failed");

// next-cycle implication, off during reset
`define PSD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("point_segment_distance assertion failed");

// next-cycle implication, always on
`define PSD_ASSERT_ALW(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("point_segment_distance assertion failed");

`endif

>>> sv/psd_pkg.sv
// shared types for the point to segment distance block
package psd_pkg;

   typedef enum logic [1:0] {
      REGION_START    = 2'd0,
      REGION_END      = 2'd1,
      REGION_INTERIOR = 2'd2,
      REGION_ZERO     = 2'd3
   } region_type;

endpackage

>>> sv/psd_if.sv
// request and response channel interfaces
interface psd_req_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   modport source (output valid, start_x, start_y, end_x, end_y, point_x, point_y,
                   input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, point_x, point_y,
                 output ready);
endinterface

interface psd_rsp_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic [2*COORD_WIDTH+2:0]      squared_distance;
   logic signed [COORD_WIDTH-1:0] nearest_x;
   logic signed [COORD_WIDTH-1:0] nearest_y;
   logic [1:0]                    region;
   modport source (output valid, squared_distance, nearest_x, nearest_y, region,
                   input ready);
   modport sink (input valid, squared_distance, nearest_x, nearest_y, region,
                 output ready);
endinterface

>>> sv/psd_front.sv
// front pipeline: differences, products, dot sums, region and e squared
module psd_front import psd_pkg::*; #(
   parameter int W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [W-1:0]     start_x,
   input  logic signed [W-1:0]     start_y,
   input  logic signed [W-1:0]     end_x,
   input  logic signed [W-1:0]     end_y,
   input  logic signed [W-1:0]     point_x,
   input  logic signed [W-1:0]     point_y,
   output logic                    out_valid,
   output logic signed [W-1:0]     out_sx,
   output logic signed [W-1:0]     out_sy,
   output logic signed [W-1:0]     out_ex,
   output logic signed [W-1:0]     out_ey,
   output logic signed [W:0]       out_dx,
   output logic signed [W:0]       out_dy,
   output region_type              out_region,
   output logic [2*W+2:0]          out_dps,
   output logic [2*W+2:0]          out_dpe,
   output logic [2*W+2:0]          out_f,
   output logic [2*W+2:0]          out_e,
   output logic [2*W+2:0]          out_rq,
   output logic [2*W+2:0]          out_lq
);
   localparam int D  = W + 1;
   localparam int P  = 2 * W + 2;
   localparam int DW = 2 * W + 3;
   localparam int H  = (DW + 1) / 2;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // stage 1
   logic signed [W-1:0] sx1_ff, sy1_ff, ex1_ff, ey1_ff;
   logic signed [D-1:0] dx1_ff, dy1_ff, vx1_ff, vy1_ff, wx1_ff, wy1_ff;
   // stage 2
   logic signed [W-1:0] sx2_ff, sy2_ff, ex2_ff, ey2_ff;
   logic signed [D-1:0] dx2_ff, dy2_ff;
   logic signed [P-1:0] pe1_ff, pe2_ff, pf1_ff, pf2_ff, pd1_ff, pd2_ff, pw1_ff, pw2_ff;
   // stage 3
   logic signed [W-1:0]  sx3_ff, sy3_ff, ex3_ff, ey3_ff;
   logic signed [D-1:0]  dx3_ff, dy3_ff;
   logic signed [DW-1:0] e3_ff;
   logic [DW-1:0]        f3_ff, dps3_ff, dpe3_ff;
   // stage 4
   logic signed [W-1:0]  sx4_ff, sy4_ff, ex4_ff, ey4_ff;
   logic signed [D-1:0]  dx4_ff, dy4_ff;
   logic [DW-1:0]        f4_ff, dps4_ff, dpe4_ff, eu4_ff;
   region_type           region4_ff, region4_in;
   logic [DW+H-1:0]      ppl4_ff;
   logic [2*DW-H-1:0]    pph4_ff;
   // stage 5
   logic [2*DW-1:0]      sq5_ff;
   logic signed [W-1:0]  sx5_ff, sy5_ff, ex5_ff, ey5_ff;
   logic signed [D-1:0]  dx5_ff, dy5_ff;
   logic [DW-1:0]        f5_ff, dps5_ff, dpe5_ff, eu5_ff;
   region_type           region5_ff;

   logic [DW-1:0] eu3;
   assign eu3 = e3_ff[DW-1:0];

   always_comb begin
      if (f3_ff == '0) begin
         region4_in = REGION_ZERO;
      end else if (e3_ff[DW-1] || (e3_ff == '0)) begin
         region4_in = REGION_START;
      end else if (eu3 >= f3_ff) begin
         region4_in = REGION_END;
      end else begin
         region4_in = REGION_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx1_ff <= start_x;
         sy1_ff <= start_y;
         ex1_ff <= end_x;
         ey1_ff <= end_y;
         dx1_ff <= D'(end_x) - D'(start_x);
         dy1_ff <= D'(end_y) - D'(start_y);
         vx1_ff <= D'(point_x) - D'(start_x);
         vy1_ff <= D'(point_y) - D'(start_y);
         wx1_ff <= D'(point_x) - D'(end_x);
         wy1_ff <= D'(point_y) - D'(end_y);

         sx2_ff <= sx1_ff;
         sy2_ff <= sy1_ff;
         ex2_ff <= ex1_ff;
         ey2_ff <= ey1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         pe1_ff <= P'(vx1_ff) * P'(dx1_ff);
         pe2_ff <= P'(vy1_ff) * P'(dy1_ff);
         pf1_ff <= P'(dx1_ff) * P'(dx1_ff);
         pf2_ff <= P'(dy1_ff) * P'(dy1_ff);
         pd1_ff <= P'(vx1_ff) * P'(vx1_ff);
         pd2_ff <= P'(vy1_ff) * P'(vy1_ff);
         pw1_ff <= P'(wx1_ff) * P'(wx1_ff);
         pw2_ff <= P'(wy1_ff) * P'(wy1_ff);

         sx3_ff  <= sx2_ff;
         sy3_ff  <= sy2_ff;
         ex3_ff  <= ex2_ff;
         ey3_ff  <= ey2_ff;
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         e3_ff   <= DW'(pe1_ff) + DW'(pe2_ff);
         f3_ff   <= DW'($unsigned(pf1_ff)) + DW'($unsigned(pf2_ff));
         dps3_ff <= DW'($unsigned(pd1_ff)) + DW'($unsigned(pd2_ff));
         dpe3_ff <= DW'($unsigned(pw1_ff)) + DW'($unsigned(pw2_ff));

         // e squared as two partial products
         sx4_ff     <= sx3_ff;
         sy4_ff     <= sy3_ff;
         ex4_ff     <= ex3_ff;
         ey4_ff     <= ey3_ff;
         dx4_ff     <= dx3_ff;
         dy4_ff     <= dy3_ff;
         f4_ff      <= f3_ff;
         dps4_ff    <= dps3_ff;
         dpe4_ff    <= dpe3_ff;
         eu4_ff     <= eu3;
         region4_ff <= region4_in;
         ppl4_ff    <= (DW+H)'(eu3) * (DW+H)'(eu3[H-1:0]);
         pph4_ff    <= (2*DW-H)'(eu3) * (2*DW-H)'(eu3[DW-1:H]);

         sq5_ff     <= {pph4_ff, {H{1'b0}}} + (2*DW)'(ppl4_ff);
         sx5_ff     <= sx4_ff;
         sy5_ff     <= sy4_ff;
         ex5_ff     <= ex4_ff;
         ey5_ff     <= ey4_ff;
         dx5_ff     <= dx4_ff;
         dy5_ff     <= dy4_ff;
         f5_ff      <= f4_ff;
         dps5_ff    <= dps4_ff;
         dpe5_ff    <= dpe4_ff;
         eu5_ff     <= eu4_ff;
         region5_ff <= region4_ff;
      end
   end

   assign out_valid  = v5_ff;
   assign out_sx     = sx5_ff;
   assign out_sy     = sy5_ff;
   assign out_ex     = ex5_ff;
   assign out_ey     = ey5_ff;
   assign out_dx     = dx5_ff;
   assign out_dy     = dy5_ff;
   assign out_region = region5_ff;
   assign out_dps    = dps5_ff;
   assign out_dpe    = dpe5_ff;
   assign out_f      = f5_ff;
   assign out_e      = eu5_ff;
   assign out_rq     = sq5_ff[2*DW-1:DW];
   assign out_lq     = sq5_ff[DW-1:0];

endmodule

>>> sv/psd_div_cell.sv
// one restoring division step for the distance and the ratio quotients
module psd_div_cell #(
   parameter int DW   = 35,
   parameter int R    = 16,
   parameter int PW   = 174,
   parameter bit Q_ON = 1'b1,
   parameter bit T_ON = 1'b1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_f,
   input  logic [DW-1:0] in_rq,
   input  logic [DW-1:0] in_lq,
   input  logic [DW-1:0] in_rt,
   input  logic [R-1:0]  in_qt,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [DW-1:0] out_f,
   output logic [DW-1:0] out_rq,
   output logic [DW-1:0] out_lq,
   output logic [DW-1:0] out_rt,
   output logic [R-1:0]  out_qt,
   output logic [PW-1:0] out_pay
);
   logic          valid_ff;
   logic [DW-1:0] f_ff, rq_ff, lq_ff, rt_ff;
   logic [R-1:0]  qt_ff;
   logic [PW-1:0] pay_ff;
   logic [DW-1:0] rq_in, lq_in, rt_in;
   logic [R-1:0]  qt_in;
   logic [DW:0]   rq2, rt2, fx;
   logic          geq, get;

   always_comb begin
      fx  = {1'b0, in_f};
      // distance quotient: shift next dividend bit into the remainder
      rq2 = {in_rq, in_lq[DW-1]};
      geq = rq2 >= fx;
      // ratio quotient: dividend tail is all zero
      rt2 = {in_rt, 1'b0};
      get = rt2 >= fx;
      if (Q_ON) begin
         rq_in = geq ? DW'(rq2 - fx) : rq2[DW-1:0];
         lq_in = {in_lq[DW-2:0], geq};
      end else begin
         rq_in = in_rq;
         lq_in = in_lq;
      end
      if (T_ON) begin
         rt_in = get ? DW'(rt2 - fx) : rt2[DW-1:0];
         qt_in = {in_qt[R-2:0], get};
      end else begin
         rt_in = in_rt;
         qt_in = in_qt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff   <= in_f;
         rq_ff  <= rq_in;
         lq_ff  <= lq_in;
         rt_ff  <= rt_in;
         qt_ff  <= qt_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_f     = f_ff;
   assign out_rq    = rq_ff;
   assign out_lq    = lq_ff;
   assign out_rt    = rt_ff;
   assign out_qt    = qt_ff;
   assign out_pay   = pay_ff;

endmodule

>>> sv/psd_back.sv
// back pipeline: distance select, offset scaling, rounding and result register
module psd_back import psd_pkg::*; #(
   parameter int W = 16,
   parameter int R = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [W-1:0] sx,
   input  logic signed [W-1:0] sy,
   input  logic signed [W-1:0] ex,
   input  logic signed [W-1:0] ey,
   input  logic signed [W:0]   dx,
   input  logic signed [W:0]   dy,
   input  region_type          region,
   input  logic [2*W+2:0]      dps,
   input  logic [2*W+2:0]      dpe,
   input  logic [2*W+2:0]      q,
   input  logic [R-1:0]        t,
   output logic                out_valid,
   output logic [2*W+2:0]      squared_distance,
   output logic signed [W-1:0] nearest_x,
   output logic signed [W-1:0] nearest_y,
   output region_type          out_region
);
   localparam int D  = W + 1;
   localparam int DW = 2 * W + 3;
   localparam int M  = R + D;
   localparam logic [M-1:0] HALF = M'(1) << (R - 1);

   logic                v1_ff, v2_ff;
   logic signed [W-1:0] sx1_ff, sy1_ff, ex1_ff, ey1_ff;
   logic                negx1_ff, negy1_ff;
   logic [M-1:0]        mx1_ff, my1_ff;
   logic [DW-1:0]       dist1_ff, dist1_in;
   region_type          region1_ff;

   logic [DW-1:0]       dist2_ff;
   logic signed [W-1:0] nx2_ff, ny2_ff, nx2_in, ny2_in;
   region_type          region2_ff;

   logic [D-1:0]        absdx, absdy, offx, offy;
   logic [M-1:0]        sumx, sumy;
   logic signed [D-1:0] nxw, nyw;

   assign absdx = dx[D-1] ? D'(-dx) : D'(dx);
   assign absdy = dy[D-1] ? D'(-dy) : D'(dy);

   always_comb begin
      case (region)
         REGION_START:    dist1_in = dps;
         REGION_ZERO:     dist1_in = dps;
         REGION_END:      dist1_in = dpe;
         REGION_INTERIOR: dist1_in = (q <= dps) ? dps - q : '0;
         default:         dist1_in = dps;
      endcase
   end

   // round offsets to nearest, ties away from zero
   always_comb begin
      sumx = mx1_ff + HALF;
      sumy = my1_ff + HALF;
      offx = sumx[M-1:R];
      offy = sumy[M-1:R];
      nxw  = D'(sx1_ff) + (negx1_ff ? -$signed(offx) : $signed(offx));
      nyw  = D'(sy1_ff) + (negy1_ff ? -$signed(offy) : $signed(offy));
      case (region1_ff)
         REGION_END: begin
            nx2_in = ex1_ff;
            ny2_in = ey1_ff;
         end
         REGION_INTERIOR: begin
            nx2_in = nxw[W-1:0];
            ny2_in = nyw[W-1:0];
         end
         default: begin
            nx2_in = sx1_ff;
            ny2_in = sy1_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx1_ff     <= sx;
         sy1_ff     <= sy;
         ex1_ff     <= ex;
         ey1_ff     <= ey;
         negx1_ff   <= dx[D-1];
         negy1_ff   <= dy[D-1];
         mx1_ff     <= M'(t) * M'(absdx);
         my1_ff     <= M'(t) * M'(absdy);
         dist1_ff   <= dist1_in;
         region1_ff <= region;

         dist2_ff   <= dist1_ff;
         nx2_ff     <= nx2_in;
         ny2_ff     <= ny2_in;
         region2_ff <= region1_ff;
      end
   end

   assign out_valid        = v2_ff;
   assign squared_distance = dist2_ff;
   assign nearest_x        = nx2_ff;
   assign nearest_y        = ny2_ff;
   assign out_region       = region2_ff;

endmodule

>>> sv/point_segment_distance.sv
// top level of the point to segment squared distance block
//
//  channel | dir | fields                                         | handshake
//  req_if  | in  | start_x start_y end_x end_y point_x point_y    | valid/ready
//  rsp_if  | out | squared_distance nearest_x nearest_y region    | valid/ready
//
// one word per cycle in and out while the response is not stalled; the
// pipe is the front stages, then a row of division cells, one quotient
// bit each, then the back stages
// reset (synchronous) clears only the stage valid bits
// a stalled response freezes the whole pipe; req_if.ready follows it
module point_segment_distance import psd_pkg::*; #(
   parameter int COORD_WIDTH         = 16,
   parameter int RATIO_FRACTION_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   psd_req_if.sink    req_if,
   psd_rsp_if.source  rsp_if
);
   localparam int W  = COORD_WIDTH;
   localparam int R  = RATIO_FRACTION_BITS;
   localparam int D  = W + 1;
   localparam int DW = 2 * W + 3;
   localparam int NC = (DW > R) ? DW : R;
   // carried fields: sx sy ex ey dx dy region dps dpe
   localparam int PW = 4 * W + 2 * D + 2 + 2 * DW;

   logic en;
   logic out_valid;

   // front outputs
   logic                fv;
   logic signed [W-1:0] fsx, fsy, fex, fey;
   logic signed [D-1:0] fdx, fdy;
   region_type          fregion;
   logic [DW-1:0]       fdps, fdpe, ff, fe, frq, flq;

   // chain taps between division cells
   logic          v_w   [NC+1];
   logic [DW-1:0] f_w   [NC+1];
   logic [DW-1:0] rq_w  [NC+1];
   logic [DW-1:0] lq_w  [NC+1];
   logic [DW-1:0] rt_w  [NC+1];
   logic [R-1:0]  qt_w  [NC+1];
   logic [PW-1:0] pay_w [NC+1];

   // back inputs unpacked from the last cell
   logic signed [W-1:0] bsx, bsy, bex, bey;
   logic signed [D-1:0] bdx, bdy;
   logic [1:0]          bregion_bits;
   logic [DW-1:0]       bdps, bdpe;
   region_type          out_region;

   // whole pipe moves when the result register is free or being taken
   assign en           = !out_valid || rsp_if.ready;
   assign req_if.ready = en;
   assign rsp_if.valid = out_valid;

   psd_front #(.W(W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_if.valid),
      .start_x    (req_if.start_x),
      .start_y    (req_if.start_y),
      .end_x      (req_if.end_x),
      .end_y      (req_if.end_y),
      .point_x    (req_if.point_x),
      .point_y    (req_if.point_y),
      .out_valid  (fv),
      .out_sx     (fsx),
      .out_sy     (fsy),
      .out_ex     (fex),
      .out_ey     (fey),
      .out_dx     (fdx),
      .out_dy     (fdy),
      .out_region (fregion),
      .out_dps    (fdps),
      .out_dpe    (fdpe),
      .out_f      (ff),
      .out_e      (fe),
      .out_rq     (frq),
      .out_lq     (flq)
   );

   // e*e divides from its high half; e itself seeds the ratio remainder
   assign v_w[0]   = fv;
   assign f_w[0]   = ff;
   assign rq_w[0]  = frq;
   assign lq_w[0]  = flq;
   assign rt_w[0]  = fe;
   assign qt_w[0]  = '0;
   assign pay_w[0] = {fsx, fsy, fex, fey, fdx, fdy, fregion, fdps, fdpe};

   for (genvar i = 0; i < NC; i++) begin : g_cell
      psd_div_cell #(
         .DW   (DW),
         .R    (R),
         .PW   (PW),
         .Q_ON (i < DW),
         .T_ON (i < R)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v_w[i]),
         .in_f      (f_w[i]),
         .in_rq     (rq_w[i]),
         .in_lq     (lq_w[i]),
         .in_rt     (rt_w[i]),
         .in_qt     (qt_w[i]),
         .in_pay    (pay_w[i]),
         .out_valid (v_w[i+1]),
         .out_f     (f_w[i+1]),
         .out_rq    (rq_w[i+1]),
         .out_lq    (lq_w[i+1]),
         .out_rt    (rt_w[i+1]),
         .out_qt    (qt_w[i+1]),
         .out_pay   (pay_w[i+1])
      );
   end

   assign {bsx, bsy, bex, bey, bdx, bdy, bregion_bits, bdps, bdpe} = pay_w[NC];

   psd_back #(.W(W), .R(R)) u_back (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (v_w[NC]),
      .sx               (bsx),
      .sy               (bsy),
      .ex               (bex),
      .ey               (bey),
      .dx               (bdx),
      .dy               (bdy),
      .region           (region_type'(bregion_bits)),
      .dps              (bdps),
      .dpe              (bdpe),
      .q                (lq_w[NC]),
      .t                (qt_w[NC]),
      .out_valid        (out_valid),
      .squared_distance (rsp_if.squared_distance),
      .nearest_x        (rsp_if.nearest_x),
      .nearest_y        (rsp_if.nearest_y),
      .out_region       (out_region)
   );

   assign rsp_if.region = out_region;

endmodule

>>> sv/psd_checker.sv
// port-level checker for the point to segment distance block, with its bind
`include "point_segment_distance_assert.svh"

module psd_checker #(
   parameter int COORD_WIDTH     = 16,
   parameter int MAX_OUTSTANDING = 64
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2*COORD_WIDTH+2:0]      squared_distance,
   input logic signed [COORD_WIDTH-1:0] nearest_x,
   input logic signed [COORD_WIDTH-1:0] nearest_y,
   input logic [1:0]                    region
);
   logic [7:0] outstanding_ff, outstanding_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff + 8'(req_take) - 8'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `PSD_ASSERT_ALW(a_reset_idle, clock, reset, !rsp_valid)
   `PSD_ASSERT_IMP(a_no_orphan, clock, reset, rsp_valid, outstanding_ff != 8'd0)
   `PSD_ASSERT_IMP(a_bounded, clock, reset, 1'b1, outstanding_ff <= 8'(MAX_OUTSTANDING))
   `PSD_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(squared_distance) && $stable(nearest_x) && $stable(nearest_y) && $stable(region))

endmodule

bind point_segment_distance psd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_psd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .squared_distance (rsp_if.squared_distance),
   .nearest_x        (rsp_if.nearest_x),
   .nearest_y        (rsp_if.nearest_y),
   .region           (rsp_if.region)
);
